/* hdl/gpio_pkg.sv */
// ----------------------------------------------------------------------------
// gpio_pkg
// Shared constants and codes for the register-mapped GPIO controller.
// ----------------------------------------------------------------------------
`default_nettype none

package gpio_pkg;

    localparam int NUM_PINS        = 32;
    localparam int PINS_PER_SELECT = 10;
    localparam int FUNC_BITS       = 3;
    localparam int DATA_W          = 32;

    localparam logic [DATA_W-1:0] PIN_MASK =
        DATA_W'((64'd1 << NUM_PINS) - 64'd1);

    localparam logic [FUNC_BITS-1:0] OUT_CODE = FUNC_BITS'(1);

    localparam logic [1:0] PULL_NONE = 2'b00;
    localparam logic [1:0] PULL_DN   = 2'(1 << 0);
    localparam logic [1:0] PULL_UP   = 2'(1 << 1);

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_TICK  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        REG_SEL0   = 4'd0,
        REG_SEL1   = 4'd1,
        REG_SEL2   = 4'd2,
        REG_SEL3   = 4'd3,
        REG_SET    = 4'd4,
        REG_CLR    = 4'd5,
        REG_LEVEL  = 4'd6,
        REG_EVENT  = 4'd7,
        REG_RISE   = 4'd8,
        REG_FALL   = 4'd9,
        REG_HIGH   = 4'd10,
        REG_LOW    = 4'd11,
        REG_PULL   = 4'd12,
        REG_PULLCK = 4'd13
    } t_reg_idx;

endpackage

`default_nettype wire

/* hdl/gpio_controller_with_event_detect.sv */
// ----------------------------------------------------------------------------
// gpio_controller_with_event_detect
// 32-pin GPIO controller: function select, set/clear output latch, level
// sampling with rising/falling/high/low event detect, latched pull control.
// ----------------------------------------------------------------------------
// channel   valid     ready     payload
// request   i_valid   o_ready   i_kind, i_reg_index, i_write_data, i_pin_levels
// result    o_valid   i_ready   o_read_data, o_output_levels, o_output_enable,
//                               o_pull_up_pins, o_pull_down_pins, o_irq
//
// one request per cycle sustained while i_ready is high; the result stays valid
// in the result register until it is taken at an edge with i_ready high
// latency is the input register plus the result register; all updates are
// mask operations on the state registers
// synchronous active-low reset clears all state and both valid flags
// a stalled result holds the input register, which then holds o_ready low
// ----------------------------------------------------------------------------
`default_nettype none

module gpio_controller_with_event_detect (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [3:0]  i_reg_index,
    input  wire logic [31:0] i_write_data,
    input  wire logic [31:0] i_pin_levels,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_read_data,
    output logic [31:0]      o_output_levels,
    output logic [31:0]      o_output_enable,
    output logic [31:0]      o_pull_up_pins,
    output logic [31:0]      o_pull_down_pins,
    output logic             o_irq
);

    localparam int PC  = gpio_pkg::NUM_PINS;
    localparam int PPS = gpio_pkg::PINS_PER_SELECT;
    localparam int FB  = gpio_pkg::FUNC_BITS;
    localparam int DW  = gpio_pkg::DATA_W;

    // input register
    logic          r_in_valid;
    logic [1:0]    r_in_kind;
    logic [3:0]    r_in_reg_index;
    logic [DW-1:0] r_in_write_data;
    logic [DW-1:0] r_in_pin_levels;

    // state
    logic [FB-1:0] r_func [PC];
    logic [FB-1:0] n_func [PC];
    logic [DW-1:0] r_latch, n_latch;
    logic [DW-1:0] r_last, n_last;
    logic [DW-1:0] r_event, n_event;
    logic [DW-1:0] r_rise, n_rise;
    logic [DW-1:0] r_fall, n_fall;
    logic [DW-1:0] r_high, n_high;
    logic [DW-1:0] r_low, n_low;
    logic [1:0]    r_pull, n_pull;
    logic [DW-1:0] r_pup, n_pup;
    logic [DW-1:0] r_pdn, n_pdn;

    // result register
    logic          r_out_valid;
    logic [DW-1:0] r_rd, n_rd;
    logic [DW-1:0] r_oe, n_oe;
    logic [DW-1:0] r_lvl;
    logic          r_irq;

    logic          advance;
    logic [DW-1:0] data_m;
    logic [DW-1:0] lvl_m;
    logic [DW-1:0] ev;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign data_m  = r_in_write_data & gpio_pkg::PIN_MASK;
    assign lvl_m   = r_in_pin_levels & gpio_pkg::PIN_MASK;
    assign ev      = (lvl_m & ~r_last & r_rise) | (~lvl_m & r_last & r_fall)
                   | (lvl_m & r_high) | (~lvl_m & gpio_pkg::PIN_MASK & r_low);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_kind       <= i_kind;
            r_in_reg_index  <= i_reg_index;
            r_in_write_data <= i_write_data;
            r_in_pin_levels <= i_pin_levels;
        end
    end

    // state update
    always_comb begin
        n_func  = r_func;
        n_latch = r_latch;
        n_last  = r_last;
        n_event = r_event;
        n_rise  = r_rise;
        n_fall  = r_fall;
        n_high  = r_high;
        n_low   = r_low;
        n_pull  = r_pull;
        n_pup   = r_pup;
        n_pdn   = r_pdn;
        n_rd    = '0;
        unique case (gpio_pkg::t_kind'(r_in_kind))
            gpio_pkg::KIND_WRITE: begin
                unique case (gpio_pkg::t_reg_idx'(r_in_reg_index))
                    gpio_pkg::REG_SEL0, gpio_pkg::REG_SEL1,
                    gpio_pkg::REG_SEL2, gpio_pkg::REG_SEL3: begin
                        for (int p = 0; p < PC; p++) begin
                            if ((p / PPS) == int'(r_in_reg_index)
                                && ((p % PPS) * FB + FB) <= DW) begin
                                n_func[p] = r_in_write_data[(p % PPS) * FB +: FB];
                            end
                        end
                    end
                    gpio_pkg::REG_SET:   n_latch = r_latch | data_m;
                    gpio_pkg::REG_CLR:   n_latch = r_latch & ~r_in_write_data;
                    gpio_pkg::REG_EVENT: n_event = r_event & ~r_in_write_data;
                    gpio_pkg::REG_RISE:  n_rise = data_m;
                    gpio_pkg::REG_FALL:  n_fall = data_m;
                    gpio_pkg::REG_HIGH:  n_high = data_m;
                    gpio_pkg::REG_LOW:   n_low = data_m;
                    gpio_pkg::REG_PULL:  n_pull = r_in_write_data[1:0];
                    gpio_pkg::REG_PULLCK: begin
                        unique case (r_pull)
                            gpio_pkg::PULL_UP: begin
                                n_pup = r_pup | data_m;
                                n_pdn = r_pdn & ~data_m;
                            end
                            gpio_pkg::PULL_DN: begin
                                n_pdn = r_pdn | data_m;
                                n_pup = r_pup & ~data_m;
                            end
                            gpio_pkg::PULL_NONE: begin
                                n_pup = r_pup & ~data_m;
                                n_pdn = r_pdn & ~data_m;
                            end
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
            gpio_pkg::KIND_READ: begin
                unique case (gpio_pkg::t_reg_idx'(r_in_reg_index))
                    gpio_pkg::REG_SEL0, gpio_pkg::REG_SEL1,
                    gpio_pkg::REG_SEL2, gpio_pkg::REG_SEL3: begin
                        for (int p = 0; p < PC; p++) begin
                            if ((p / PPS) == int'(r_in_reg_index)
                                && ((p % PPS) * FB + FB) <= DW) begin
                                n_rd[(p % PPS) * FB +: FB] = r_func[p];
                            end
                        end
                    end
                    gpio_pkg::REG_LEVEL: n_rd = r_last;
                    gpio_pkg::REG_EVENT: n_rd = r_event;
                    gpio_pkg::REG_RISE:  n_rd = r_rise;
                    gpio_pkg::REG_FALL:  n_rd = r_fall;
                    gpio_pkg::REG_HIGH:  n_rd = r_high;
                    gpio_pkg::REG_LOW:   n_rd = r_low;
                    gpio_pkg::REG_PULL:  n_rd = {{(DW - 2){1'b0}}, r_pull};
                    default: ;
                endcase
            end
            gpio_pkg::KIND_TICK: begin
                n_event = r_event | (ev & gpio_pkg::PIN_MASK);
                n_last  = lvl_m;
            end
            default: ;
        endcase
    end

    // output enable from the updated function codes
    always_comb begin
        n_oe = '0;
        for (int p = 0; p < PC; p++) begin
            n_oe[p] = (n_func[p] == gpio_pkg::OUT_CODE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PC; p++) begin
                r_func[p] <= '0;
            end
            r_latch <= '0;
            r_last  <= '0;
            r_event <= '0;
            r_rise  <= '0;
            r_fall  <= '0;
            r_high  <= '0;
            r_low   <= '0;
            r_pull  <= '0;
            r_pup   <= '0;
            r_pdn   <= '0;
        end else if (advance) begin
            r_func  <= n_func;
            r_latch <= n_latch;
            r_last  <= n_last;
            r_event <= n_event;
            r_rise  <= n_rise;
            r_fall  <= n_fall;
            r_high  <= n_high;
            r_low   <= n_low;
            r_pull  <= n_pull;
            r_pup   <= n_pup;
            r_pdn   <= n_pdn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_rd  <= n_rd;
            r_oe  <= n_oe;
            r_lvl <= n_latch & gpio_pkg::PIN_MASK;
            r_irq <= (n_event != '0);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_read_data      = r_rd;
    assign o_output_levels  = r_lvl;
    assign o_output_enable  = r_oe;
    assign o_pull_up_pins   = r_pup;
    assign o_pull_down_pins = r_pdn;
    assign o_irq            = r_irq;

`ifndef ASSERT_OFF
    a_pull_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pup & r_pdn) == '0)
        else $error("pin with both pull-up and pull-down");

    a_advance_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_valid)
        else $error("processed request produced no result");

    a_held_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_kind)
            && $stable(r_in_reg_index))
        else $error("stalled request lost or changed");

    a_irq_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_irq == (r_event != '0))
        else $error("irq does not match event status");
`endif

endmodule

`default_nettype wire

/* verif/gpio_controller_with_event_detect_tb.sv */
// ----------------------------------------------------------------------------
// gpio_controller_with_event_detect_tb
// Self-checking bench for the GPIO controller. A register shadow tracks
// function codes, the output latch, event detect and pull state, and predicts
// the result of every accepted request. Directed requests hit the extremes,
// every register but the high and low enables, and every pull code. Random
// register traffic and pin ticks follow, with random gaps on the request side
// and random stalls on the result side.
// ----------------------------------------------------------------------------
module gpio_controller_with_event_detect_tb;

    typedef struct packed {
        logic [31:0] read_data;
        logic [31:0] output_levels;
        logic [31:0] output_enable;
        logic [31:0] pull_up;
        logic [31:0] pull_dn;
        logic        irq;
    } t_gpio_result;

    class gpio_register_shadow;
        logic [gpio_pkg::FUNC_BITS-1:0] func_codes [gpio_pkg::NUM_PINS];
        logic [31:0] out_latch;
        logic [31:0] last_lvl;
        logic [31:0] events;
        logic [31:0] rise_en;
        logic [31:0] fall_en;
        logic [31:0] high_en;
        logic [31:0] low_en;
        logic [1:0]  pull_ctl;
        logic [31:0] pull_up;
        logic [31:0] pull_dn;
        t_gpio_result pending_results[$];
        int fails;
        int n_checked;
        int n_irq;

        function new();
            foreach (func_codes[p]) func_codes[p] = '0;
            out_latch = '0;
            last_lvl  = '0;
            events    = '0;
            rise_en   = '0;
            fall_en   = '0;
            high_en   = '0;
            low_en    = '0;
            pull_ctl  = gpio_pkg::PULL_NONE;
            pull_up   = '0;
            pull_dn   = '0;
            fails     = 0;
            n_checked = 0;
            n_irq     = 0;
        endfunction

        function void note_request(logic [1:0] kind, logic [3:0] idx,
                                   logic [31:0] data, logic [31:0] levels);
            t_gpio_result want;
            logic [31:0]  rd;
            logic [31:0]  nw;
            logic [31:0]  d;
            int           pin;
            rd = '0;
            if (kind == gpio_pkg::KIND_WRITE) begin
                if (idx <= gpio_pkg::REG_SEL3) begin
                    for (int k = 0; k < gpio_pkg::PINS_PER_SELECT; k++) begin
                        pin = idx * gpio_pkg::PINS_PER_SELECT + k;
                        if (k * gpio_pkg::FUNC_BITS + gpio_pkg::FUNC_BITS <= 32
                            && pin < gpio_pkg::NUM_PINS)
                            func_codes[pin] =
                                data[k*gpio_pkg::FUNC_BITS +: gpio_pkg::FUNC_BITS];
                    end
                end else begin
                    case (idx)
                        gpio_pkg::REG_SET:
                            out_latch = out_latch | (data & gpio_pkg::PIN_MASK);
                        gpio_pkg::REG_CLR:   out_latch = out_latch & ~data;
                        gpio_pkg::REG_EVENT: events = events & ~data;
                        gpio_pkg::REG_RISE:  rise_en = data & gpio_pkg::PIN_MASK;
                        gpio_pkg::REG_FALL:  fall_en = data & gpio_pkg::PIN_MASK;
                        gpio_pkg::REG_HIGH:  high_en = data & gpio_pkg::PIN_MASK;
                        gpio_pkg::REG_LOW:   low_en = data & gpio_pkg::PIN_MASK;
                        gpio_pkg::REG_PULL:  pull_ctl = data[1:0];
                        gpio_pkg::REG_PULLCK: begin
                            d = data & gpio_pkg::PIN_MASK;
                            if (pull_ctl == gpio_pkg::PULL_UP) begin
                                pull_up = pull_up | d;
                                pull_dn = pull_dn & ~d;
                            end else if (pull_ctl == gpio_pkg::PULL_DN) begin
                                pull_dn = pull_dn | d;
                                pull_up = pull_up & ~d;
                            end else if (pull_ctl == gpio_pkg::PULL_NONE) begin
                                pull_up = pull_up & ~d;
                                pull_dn = pull_dn & ~d;
                            end
                        end
                        default: ;
                    endcase
                end
            end else if (kind == gpio_pkg::KIND_READ) begin
                if (idx <= gpio_pkg::REG_SEL3) begin
                    for (int k = 0; k < gpio_pkg::PINS_PER_SELECT; k++) begin
                        pin = idx * gpio_pkg::PINS_PER_SELECT + k;
                        if (k * gpio_pkg::FUNC_BITS + gpio_pkg::FUNC_BITS <= 32
                            && pin < gpio_pkg::NUM_PINS)
                            rd[k*gpio_pkg::FUNC_BITS +: gpio_pkg::FUNC_BITS] =
                                func_codes[pin];
                    end
                end else begin
                    case (idx)
                        gpio_pkg::REG_LEVEL: rd = last_lvl;
                        gpio_pkg::REG_EVENT: rd = events;
                        gpio_pkg::REG_RISE:  rd = rise_en;
                        gpio_pkg::REG_FALL:  rd = fall_en;
                        gpio_pkg::REG_HIGH:  rd = high_en;
                        gpio_pkg::REG_LOW:   rd = low_en;
                        gpio_pkg::REG_PULL:  rd = {30'd0, pull_ctl};
                        default:             rd = '0;
                    endcase
                end
            end else if (kind == gpio_pkg::KIND_TICK) begin
                nw = levels & gpio_pkg::PIN_MASK;
                events = events | (((nw & ~last_lvl & rise_en)
                                  | (~nw & last_lvl & fall_en)
                                  | (nw & high_en)
                                  | (~nw & gpio_pkg::PIN_MASK & low_en))
                                  & gpio_pkg::PIN_MASK);
                last_lvl = nw;
            end
            want.read_data     = rd;
            want.output_levels = out_latch & gpio_pkg::PIN_MASK;
            want.output_enable = '0;
            for (int p = 0; p < gpio_pkg::NUM_PINS; p++)
                if (func_codes[p] == gpio_pkg::OUT_CODE) want.output_enable[p] = 1'b1;
            want.pull_up   = pull_up;
            want.pull_dn   = pull_dn;
            want.irq       = (events != '0);
            pending_results.push_back(want);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] exp_val);
            fails++;
            $display("mismatch at %0t: %s got %h expected %h",
                     $realtime, what, got, exp_val);
        endtask

        task check_result(t_gpio_result got);
            t_gpio_result want;
            n_checked++;
            if (got.irq === 1'b1) n_irq++;
            if (pending_results.size() == 0) begin
                report("result with no request waiting", got.read_data, '0);
            end else begin
                want = pending_results.pop_front();
                if (got.read_data !== want.read_data)
                    report("read_data", got.read_data, want.read_data);
                if (got.output_levels !== want.output_levels)
                    report("output_levels", got.output_levels, want.output_levels);
                if (got.output_enable !== want.output_enable)
                    report("output_enable", got.output_enable, want.output_enable);
                if (got.pull_up !== want.pull_up)
                    report("pull_up_pins", got.pull_up, want.pull_up);
                if (got.pull_dn !== want.pull_dn)
                    report("pull_down_pins", got.pull_dn, want.pull_dn);
                if (got.irq !== want.irq)
                    report("irq", {31'd0, got.irq}, {31'd0, want.irq});
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_kind;
    logic [3:0]  i_reg_index;
    logic [31:0] i_write_data;
    logic [31:0] i_pin_levels;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_read_data;
    logic [31:0] o_output_levels;
    logic [31:0] o_output_enable;
    logic [31:0] o_pull_up_pins;
    logic [31:0] o_pull_down_pins;
    logic        o_irq;

    gpio_register_shadow shadow;
    t_gpio_result        seen;
    bit                  req_calm;
    bit                  rsp_calm;
    int                  n_writes;
    int                  n_reads;
    int                  n_ticks;

    gpio_controller_with_event_detect dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_kind           (i_kind),
        .i_reg_index      (i_reg_index),
        .i_write_data     (i_write_data),
        .i_pin_levels     (i_pin_levels),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_read_data      (o_read_data),
        .o_output_levels  (o_output_levels),
        .o_output_enable  (o_output_enable),
        .o_pull_up_pins   (o_pull_up_pins),
        .o_pull_down_pins (o_pull_down_pins),
        .o_irq            (o_irq)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results still waiting",
                 shadow.pending_results.size());
        $display("gpio_controller_with_event_detect_tb failed");
        $finish;
    end

    // result side: random stalls, with calm stretches of back-to-back accepts
    initial begin
        int gap;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 31) == 0) rsp_calm = !rsp_calm;
            gap = rsp_calm ? 0 : $urandom_range(0, 15);
            @(negedge i_clk);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen.read_data     = o_read_data;
            seen.output_levels = o_output_levels;
            seen.output_enable = o_output_enable;
            seen.pull_up       = o_pull_up_pins;
            seen.pull_dn       = o_pull_down_pins;
            seen.irq           = o_irq;
            shadow.check_result(seen);
        end
    end

    task automatic send_request(logic [1:0] kind, logic [3:0] idx,
                                logic [31:0] data, logic [31:0] levels);
        int gap;
        if ($urandom_range(0, 31) == 0) req_calm = !req_calm;
        gap = req_calm ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_reg_index  <= idx;
        i_write_data <= data;
        i_pin_levels <= levels;
        do @(posedge i_clk); while (!o_ready);
        shadow.note_request(kind, idx, data, levels);
        case (kind)
            gpio_pkg::KIND_WRITE: n_writes++;
            gpio_pkg::KIND_READ:  n_reads++;
            default:              n_ticks++;
        endcase
    endtask

    task automatic write_reg(logic [3:0] idx, logic [31:0] data);
        send_request(gpio_pkg::KIND_WRITE, idx, data, $urandom);
    endtask

    task automatic read_reg(logic [3:0] idx);
        send_request(gpio_pkg::KIND_READ, idx, $urandom, $urandom);
    endtask

    task automatic tick_pins(logic [31:0] levels);
        send_request(gpio_pkg::KIND_TICK, 4'($urandom_range(0, 13)), $urandom, levels);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 32'd1 << $urandom_range(0, 31);
            3:       return $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    // select words leaning toward the output code so output_enable moves
    function automatic logic [31:0] sel_word();
        logic [31:0] w;
        w = $urandom;
        for (int k = 0; k < gpio_pkg::PINS_PER_SELECT; k++)
            if ($urandom_range(0, 1) == 1)
                w[k*gpio_pkg::FUNC_BITS +: gpio_pkg::FUNC_BITS] = gpio_pkg::OUT_CODE;
        return w;
    endfunction

    initial begin
        int r;
        shadow       = new();
        req_calm     = 1'b0;
        rsp_calm     = 1'b0;
        n_writes     = 0;
        n_reads      = 0;
        n_ticks      = 0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_kind       = gpio_pkg::KIND_WRITE;
        i_reg_index  = gpio_pkg::REG_SEL0;
        i_write_data = '0;
        i_pin_levels = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // function select extremes, then every pin an output
        write_reg(gpio_pkg::REG_SEL0, 32'hFFFF_FFFF);
        read_reg(gpio_pkg::REG_SEL0);
        write_reg(gpio_pkg::REG_SEL0, 32'h0924_9249);
        write_reg(gpio_pkg::REG_SEL1, 32'h0924_9249);
        write_reg(gpio_pkg::REG_SEL2, 32'h0924_9249);
        write_reg(gpio_pkg::REG_SEL3, 32'hFFFF_FFC9);
        // set, clear, write-only readback
        write_reg(gpio_pkg::REG_SET, 32'hFFFF_FFFF);
        write_reg(gpio_pkg::REG_CLR, 32'h5555_5555);
        read_reg(gpio_pkg::REG_SET);
        // edge events, status clear, ignored level write
        write_reg(gpio_pkg::REG_RISE, 32'hFFFF_FFFF);
        write_reg(gpio_pkg::REG_FALL, 32'hFFFF_FFFF);
        tick_pins(32'hFFFF_FFFF);
        tick_pins(32'h0000_0000);
        read_reg(gpio_pkg::REG_EVENT);
        write_reg(gpio_pkg::REG_EVENT, 32'hFFFF_FFFF);
        write_reg(gpio_pkg::REG_LEVEL, 32'hFFFF_FFFF);
        read_reg(gpio_pkg::REG_LEVEL);
        // every pull code, the reserved one included
        write_reg(gpio_pkg::REG_PULL, 32'(gpio_pkg::PULL_UP));
        write_reg(gpio_pkg::REG_PULLCK, 32'hF0F0_F0F0);
        write_reg(gpio_pkg::REG_PULL, 32'(gpio_pkg::PULL_DN));
        write_reg(gpio_pkg::REG_PULLCK, 32'h0FF0_0FF0);
        write_reg(gpio_pkg::REG_PULL, 32'hFFFF_FFFF);
        write_reg(gpio_pkg::REG_PULLCK, 32'hFFFF_FFFF);
        write_reg(gpio_pkg::REG_PULL, 32'(gpio_pkg::PULL_NONE));
        write_reg(gpio_pkg::REG_PULLCK, 32'h0000_FFFF);
        read_reg(gpio_pkg::REG_PULL);

        repeat (450) begin
            r = $urandom_range(0, 99);
            if (r < 15)
                tick_pins(rand_word());
            else if (r < 25)
                write_reg(4'($urandom_range(gpio_pkg::REG_SEL0, gpio_pkg::REG_SEL3)),
                          sel_word());
            else if (r < 35)
                write_reg(4'($urandom_range(gpio_pkg::REG_SET, gpio_pkg::REG_CLR)),
                          rand_word());
            else if (r < 45)
                write_reg(gpio_pkg::REG_EVENT, rand_word());
            else if (r < 55)
                write_reg(4'($urandom_range(gpio_pkg::REG_RISE, gpio_pkg::REG_LOW)),
                          rand_word());
            else if (r < 65)
                write_reg(gpio_pkg::REG_PULL,
                          ($urandom & ~32'd3) | $urandom_range(0, 3));
            else if (r < 72)
                write_reg(gpio_pkg::REG_PULLCK, rand_word());
            else if (r < 75)
                write_reg(gpio_pkg::REG_LEVEL, rand_word());
            else
                read_reg(4'($urandom_range(gpio_pkg::REG_SEL0, gpio_pkg::REG_PULLCK)));
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (shadow.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (shadow.pending_results.size() != 0)
            shadow.report("requests left without a result",
                          shadow.pending_results.size(), '0);

        $display("requests: %0d writes, %0d reads, %0d pin ticks",
                 n_writes, n_reads, n_ticks);
        $display("results checked: %0d, %0d with irq raised",
                 shadow.n_checked, shadow.n_irq);
        if (shadow.fails == 0)
            $display("gpio_controller_with_event_detect_tb passed");
        else
            $display("gpio_controller_with_event_detect_tb failed");
        $finish;
    end

endmodule

/* files.f */
hdl/gpio_pkg.sv
hdl/gpio_controller_with_event_detect.sv
verif/gpio_controller_with_event_detect_tb.sv
